// File: hdl/unsigned_divider_64_top_defines.svh
`ifndef UNSIGNED_DIVIDER_64_TOP_DEFINES_SVH
`define UNSIGNED_DIVIDER_64_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define UDIV64_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define UDIV64_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/udiv64_pkg.sv
`default_nettype none

package udiv64_pkg;

    localparam int DATA_WIDTH = 64;
    localparam int FIELD_W    = 64;
    localparam int CNT_W      = $clog2(DATA_WIDTH);

    typedef logic [DATA_WIDTH-1:0] t_data;
    typedef logic [FIELD_W-1:0]    t_field;
    typedef logic [CNT_W-1:0]      t_cnt;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_HOLD
    } t_state;

    typedef struct packed {
        logic take;
        logic load;
        logic step;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic den_zero;
        logic last;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// File: hdl/udiv64_in_if.sv
`default_nettype none

interface udiv64_in_if import udiv64_pkg::*; ();
    logic   valid;
    logic   ready;
    t_field dividend;
    t_field divisor_value;

    modport source (output valid, dividend, divisor_value, input ready);
    modport sink   (input valid, dividend, divisor_value, output ready);
endinterface

`default_nettype wire

// File: hdl/udiv64_out_if.sv
`default_nettype none

interface udiv64_out_if import udiv64_pkg::*; ();
    logic   valid;
    logic   ready;
    t_field quotient;
    logic   divide_by_zero;

    modport source (output valid, quotient, divide_by_zero, input ready);
    modport sink   (input valid, quotient, divide_by_zero, output ready);
endinterface

`default_nettype wire

// File: hdl/udiv64_ctrl.sv
`default_nettype none

module udiv64_ctrl import udiv64_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.take = 1'b1;
                if (i_sts.in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.den_zero ? S_HOLD : S_RUN;
                end
            end
            S_RUN: begin
                o_cmd.step = 1'b1;
                if (i_sts.last) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (i_sts.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/udiv64_dp.sv
`default_nettype none

module udiv64_dp import udiv64_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_cmd    i_cmd,
    output t_sts         o_sts,
    udiv64_in_if.sink    i_req,
    udiv64_out_if.source o_rsp
);

    t_data r_rem,  n_rem;
    t_data r_quo,  n_quo;
    t_data r_den,  n_den;
    t_cnt  r_cnt,  n_cnt;
    logic  r_dbz,  n_dbz;
    t_data r_oq;
    logic  r_odbz;
    logic  r_ovalid;

    logic [DATA_WIDTH:0] w_part;
    logic [DATA_WIDTH:0] w_diff;
    t_data               w_den_in;

    assign w_den_in = i_req.divisor_value[DATA_WIDTH-1:0];
    assign w_part   = {r_rem, r_quo[DATA_WIDTH-1]};
    assign w_diff   = w_part - {1'b0, r_den};

    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        n_den = r_den;
        n_cnt = r_cnt;
        n_dbz = r_dbz;
        if (i_cmd.load) begin
            n_rem = '0;
            n_den = w_den_in;
            n_cnt = '0;
            n_dbz = (w_den_in == '0);
            n_quo = n_dbz ? '1 : i_req.dividend[DATA_WIDTH-1:0];
        end else if (i_cmd.step) begin
            n_cnt = r_cnt + 1'b1;
            // quotient bits shift in as dividend bits shift out
            if (!w_diff[DATA_WIDTH]) begin
                n_rem = w_diff[DATA_WIDTH-1:0];
                n_quo = {r_quo[DATA_WIDTH-2:0], 1'b1};
            end else begin
                n_rem = w_part[DATA_WIDTH-1:0];
                n_quo = {r_quo[DATA_WIDTH-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
        r_cnt <= n_cnt;
        r_dbz <= n_dbz;
        if (i_cmd.push) begin
            r_oq   <= r_quo;
            r_odbz <= r_dbz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.push) begin
            r_ovalid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign i_req.ready          = i_cmd.take;
    assign o_rsp.valid          = r_ovalid;
    assign o_rsp.quotient       = FIELD_W'(r_oq);
    assign o_rsp.divide_by_zero = r_odbz;

    assign o_sts.in_valid = i_req.valid;
    assign o_sts.den_zero = (w_den_in == '0);
    assign o_sts.last     = (r_cnt == CNT_W'(DATA_WIDTH - 1));
    assign o_sts.out_free = !r_ovalid || o_rsp.ready;

endmodule

`default_nettype wire

// File: hdl/unsigned_divider_64_top.sv
// Unsigned restoring divider: returns floor(dividend / divisor_value) over the
// low DATA_WIDTH bits of each operand, one quotient bit per cycle from a single
// shared subtract-and-compare stage. An accepted request runs one step per
// quotient bit, then holds until the output register is free; a zero divisor
// skips the steps and returns an all-ones quotient with divide_by_zero set. One
// request is in work at a time; a finished quotient waits in an output register,
// so a new request is accepted while the previous result is still pending.
`default_nettype none

`include "unsigned_divider_64_top_defines.svh"

module unsigned_divider_64_top import udiv64_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    udiv64_in_if.sink    i_req,
    udiv64_out_if.source o_rsp
);

    t_cmd w_cmd;
    t_sts w_sts;

    udiv64_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    udiv64_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

    `UDIV64_ASSERT_NOW(a_dbz_all_ones, i_clk, i_rst_n, o_rsp.valid && o_rsp.divide_by_zero, &o_rsp.quotient[DATA_WIDTH-1:0], "zero divisor result not all ones")
    `UDIV64_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_req.valid && i_req.ready, !i_req.ready, "request taken while busy")
    `UDIV64_ASSERT_NOW(a_push_into_free, i_clk, i_rst_n, w_cmd.push, !o_rsp.valid || o_rsp.ready, "result pushed over pending result")

endmodule

`default_nettype wire
